[hw/rtl/bmf_pkg.sv]
// Shared types and constants of the 9x9 box mean filter.
package bmf_pkg;

    localparam int PIXEL_W     = 8;
    localparam int PIXEL_MAX   = 255;
    localparam int FRAC_W      = 8;
    localparam int MEAN_W      = 16;
    localparam int COL_W       = 10;
    localparam int ROW_W       = 16;
    localparam int EXT_WIDTH_W = 11;
    localparam int EXT_HEIGHT_W = 16;
    localparam int CFG_INDEX_W = 8;
    localparam int CFG_DATA_W  = 16;

    localparam logic [MEAN_W-1:0]       MEAN_MAX          = 16'hFFFF;
    localparam logic [EXT_WIDTH_W-1:0]  EXT_WIDTH_RESET   = 11'd1024;
    localparam logic [EXT_HEIGHT_W-1:0] EXT_HEIGHT_RESET  = 16'd1024;

    localparam logic [CFG_INDEX_W-1:0] CFG_EXT_WIDTH  = 8'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_EXT_HEIGHT = 8'd1;

    typedef struct packed {
        logic emit;
        logic row_end;
        logic frame_end;
    } bmf_flags_t;

endpackage

[hw/rtl/bmf_raster_ctrl.sv]
// Raster position counters, line store slot and per-pixel output flags.
module bmf_raster_ctrl import bmf_pkg::*; #(
    parameter int FILTER_REACH = 4,
    parameter int LINE_MAX     = 1024,
    localparam int SLOT_W      = $clog2(LINE_MAX)
) (
    input  logic                    aclk,
    input  logic                    aresetn,
    input  logic                    advance,
    input  logic [EXT_WIDTH_W-1:0]  ext_width,
    input  logic [EXT_HEIGHT_W-1:0] ext_height,
    output logic [SLOT_W-1:0]       slot,
    output bmf_flags_t              flags
);

    localparam int HIST_ROWS = 2 * FILTER_REACH;
    localparam int LM_W      = $clog2(LINE_MAX + 1);
    localparam int CMP_W     = (EXT_WIDTH_W > LM_W) ? EXT_WIDTH_W : LM_W;

    logic [COL_W-1:0]  col_reg, col_next;
    logic [ROW_W-1:0]  row_reg, row_next;
    logic [SLOT_W-1:0] slot_reg, slot_next;
    logic [EXT_WIDTH_W-1:0]  eff_w;
    logic [EXT_HEIGHT_W-1:0] eff_h;
    logic last_col, last_row;

    always_comb begin
        if (CMP_W'(ext_width) > CMP_W'(LINE_MAX)) begin
            eff_w = EXT_WIDTH_W'(LINE_MAX);
        end else begin
            eff_w = ext_width;
        end
        if (eff_w == '0) begin
            eff_w = EXT_WIDTH_W'(1);
        end
        eff_h = (ext_height == '0) ? EXT_HEIGHT_W'(1) : ext_height;

        last_col = ({1'b0, col_reg} + EXT_WIDTH_W'(1)) >= eff_w;
        last_row = ({1'b0, row_reg} + (ROW_W + 1)'(1)) >= {1'b0, eff_h};

        flags.emit      = (row_reg >= ROW_W'(HIST_ROWS)) && (col_reg >= COL_W'(HIST_ROWS));
        flags.row_end   = last_col;
        flags.frame_end = last_col && last_row;

        col_next  = col_reg;
        row_next  = row_reg;
        slot_next = slot_reg;
        if (last_col) begin
            col_next  = '0;
            slot_next = '0;
            row_next  = last_row ? '0 : row_reg + ROW_W'(1);
        end else begin
            col_next = col_reg + COL_W'(1);
            if (col_reg == '1) begin
                slot_next = '0;
            end else if (({1'b0, slot_reg} + (SLOT_W + 1)'(1)) == (SLOT_W + 1)'(LINE_MAX)) begin
                slot_next = '0;
            end else begin
                slot_next = slot_reg + SLOT_W'(1);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            col_reg  <= '0;
            row_reg  <= '0;
            slot_reg <= '0;
        end else if (advance) begin
            col_reg  <= col_next;
            row_reg  <= row_next;
            slot_reg <= slot_next;
        end
    end

    assign slot = slot_reg;

endmodule

[hw/rtl/bmf_line_store.sv]
// Line store memory holding the previous rows per column, with a clearing pass after reset.
module bmf_line_store #(
    parameter int DEPTH  = 1024,
    parameter int DATA_W = 64,
    localparam int ADDR_W = $clog2(DEPTH)
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              rd_en,
    input  logic [ADDR_W-1:0] rd_addr,
    output logic [DATA_W-1:0] rd_data,
    input  logic              wr_en,
    input  logic [ADDR_W-1:0] wr_addr,
    input  logic [DATA_W-1:0] wr_data,
    output logic              clearing
);

    logic [DATA_W-1:0] mem_reg [DEPTH];
    logic [DATA_W-1:0] rd_data_reg;
    logic              clear_busy_reg;
    logic [ADDR_W-1:0] clear_addr_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            clear_busy_reg <= 1'b1;
            clear_addr_reg <= '0;
        end else if (clear_busy_reg) begin
            clear_addr_reg <= clear_addr_reg + ADDR_W'(1);
            if (clear_addr_reg == ADDR_W'(DEPTH - 1)) begin
                clear_busy_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (clear_busy_reg) begin
            mem_reg[clear_addr_reg] <= '0;
        end else if (wr_en) begin
            mem_reg[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data_reg <= mem_reg[rd_addr];
        end
    end

    assign rd_data  = rd_data_reg;
    assign clearing = clear_busy_reg;

endmodule

[hw/rtl/bmf_mean_div.sv]
// Window mean: rounded division by the tap count through a registered reciprocal multiply.
module bmf_mean_div import bmf_pkg::*; #(
    parameter int WSUM_W = 15,
    parameter int TAPS   = 81
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              en,
    input  logic              in_valid,
    input  logic [WSUM_W-1:0] in_sum,
    input  bmf_flags_t        in_flags,
    output logic              out_valid,
    output logic [MEAN_W-1:0] out_mean,
    output bmf_flags_t        out_flags
);

    localparam int N  = WSUM_W + FRAC_W;
    localparam int L  = $clog2(TAPS);
    localparam int S  = N + L;
    localparam int RW = N + 1;
    localparam int PW = N + RW;
    localparam int QW = PW - S;
    localparam logic [63:0] RECIP64 = ((64'd1 << S) + 64'(TAPS) - 64'd1) / 64'(TAPS);
    localparam logic [RW-1:0] RECIP = RW'(RECIP64);

    logic [N-1:0]  dividend;
    logic [PW-1:0] prod_next, prod_reg;
    logic          valid_reg;
    bmf_flags_t    flags_reg;
    logic [QW-1:0] quot;

    assign dividend  = {in_sum, FRAC_W'(0)} + N'(TAPS / 2);
    assign prod_next = PW'(dividend) * PW'(RECIP);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (en) begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            prod_reg  <= prod_next;
            flags_reg <= in_flags;
        end
    end

    assign quot      = QW'(prod_reg >> S);
    assign out_mean  = (quot > QW'(MEAN_MAX)) ? MEAN_MAX : MEAN_W'(quot);
    assign out_valid = valid_reg;
    assign out_flags = flags_reg;

endmodule

[hw/rtl/box_mean_filter_9x9.sv]
// Top level of the 9x9 box mean filter over a border-extended 8-bit pixel stream.
//
//  channel  | direction | handshake                  | payload
//  ---------+-----------+----------------------------+----------------------------------
//  s_       | in        | s_tvalid / s_tready        | s_tdata[7:0] pixel
//  m_       | out       | m_tvalid / m_tready        | m_tdata mean, m_tlast row end,
//           |           |                            | m_tuser[0] frame end
//  cfg_     | in        | cfg_valid / cfg_ready      | cfg_index, cfg_data
//
// One pixel per cycle once the clearing pass ends and while the m_ side is not stalled;
// a result passes the line store read, column and window sums, reciprocal multiply and output register.
// After reset a clearing pass zeroes the line store; s_tready stays low until it ends,
// while configuration writes are taken at any time.
// A stalled m_ side holds the whole pipeline, and s_tready drops with it.
module box_mean_filter_9x9 import bmf_pkg::*; #(
    parameter int FILTER_REACH = 4,
    parameter int LINE_MAX     = 1024
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   s_tvalid,
    output logic                   s_tready,
    input  logic [7:0]             s_tdata,   // [7:0] pixel
    output logic                   m_tvalid,
    input  logic                   m_tready,
    output logic [15:0]            m_tdata,   // [15:0] mean_value
    output logic                   m_tlast,   // row_end
    output logic [0:0]             m_tuser,   // [0] frame_end
    input  logic                   cfg_valid,
    output logic                   cfg_ready,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data
);

    localparam int WIN_DIM   = 2 * FILTER_REACH + 1;
    localparam int HIST_ROWS = 2 * FILTER_REACH;
    localparam int TAPS      = WIN_DIM * WIN_DIM;
    localparam int ENTRY_W   = HIST_ROWS * PIXEL_W;
    localparam int SLOT_W    = $clog2(LINE_MAX);
    localparam int CSUM_W    = $clog2(WIN_DIM * PIXEL_MAX + 1);
    localparam int WSUM_W    = $clog2(TAPS * PIXEL_MAX + 1);

    logic [EXT_WIDTH_W-1:0]  ext_width_reg;
    logic [EXT_HEIGHT_W-1:0] ext_height_reg;

    logic              en, accept, clearing;
    logic [SLOT_W-1:0] slot;
    bmf_flags_t        flags;

    logic               s1_valid_reg;
    logic [PIXEL_W-1:0] s1_pixel_reg;
    logic [SLOT_W-1:0]  s1_slot_reg;
    bmf_flags_t         s1_flags_reg;
    logic               fwd_valid_reg;
    logic [ENTRY_W-1:0] fwd_data_reg;
    logic [ENTRY_W-1:0] rd_data, hist, new_entry;
    logic [CSUM_W-1:0]  csum;

    logic [CSUM_W-1:0] col_sums_reg [WIN_DIM];
    logic [WSUM_W-1:0] window_sum_reg, window_sum_next;

    logic              s2_valid_reg;
    logic [WSUM_W-1:0] s2_sum_reg;
    bmf_flags_t        s2_flags_reg;

    logic              div_valid;
    logic [MEAN_W-1:0] div_mean;
    bmf_flags_t        div_flags;

    logic              m_valid_reg;
    logic [MEAN_W-1:0] m_mean_reg;
    logic              m_row_end_reg, m_frame_end_reg;

    assign en        = !m_valid_reg || m_tready;
    assign s_tready  = en && !clearing;
    assign accept    = s_tvalid && s_tready;
    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ext_width_reg  <= EXT_WIDTH_RESET;
            ext_height_reg <= EXT_HEIGHT_RESET;
        end else if (cfg_valid) begin
            if (cfg_index == CFG_EXT_WIDTH) begin
                ext_width_reg <= cfg_data[EXT_WIDTH_W-1:0];
            end else if (cfg_index == CFG_EXT_HEIGHT) begin
                ext_height_reg <= cfg_data[EXT_HEIGHT_W-1:0];
            end
        end
    end

    bmf_raster_ctrl #(
        .FILTER_REACH (FILTER_REACH),
        .LINE_MAX     (LINE_MAX)
    ) u_ctrl (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .advance    (accept),
        .ext_width  (ext_width_reg),
        .ext_height (ext_height_reg),
        .slot       (slot),
        .flags      (flags)
    );

    bmf_line_store #(
        .DEPTH  (LINE_MAX),
        .DATA_W (ENTRY_W)
    ) u_store (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .rd_en    (en),
        .rd_addr  (slot),
        .rd_data  (rd_data),
        .wr_en    (en && s1_valid_reg),
        .wr_addr  (s1_slot_reg),
        .wr_data  (new_entry),
        .clearing (clearing)
    );

    // Stage 1: column history (forwarded when the same slot was written at the read edge)
    assign hist      = fwd_valid_reg ? fwd_data_reg : rd_data;
    assign new_entry = {s1_pixel_reg, hist[ENTRY_W-1:PIXEL_W]};

    always_comb begin
        csum = CSUM_W'(s1_pixel_reg);
        for (int k = 0; k < HIST_ROWS; k++) begin
            csum = csum + CSUM_W'(hist[k*PIXEL_W +: PIXEL_W]);
        end
        window_sum_next = window_sum_reg + WSUM_W'(csum) - WSUM_W'(col_sums_reg[0]);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg  <= 1'b0;
            fwd_valid_reg <= 1'b0;
            s2_valid_reg  <= 1'b0;
        end else if (en) begin
            s1_valid_reg  <= accept;
            fwd_valid_reg <= accept && s1_valid_reg && (slot == s1_slot_reg);
            s2_valid_reg  <= s1_valid_reg && s1_flags_reg.emit;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            s1_pixel_reg <= s_tdata;
            s1_slot_reg  <= slot;
            s1_flags_reg <= flags;
            fwd_data_reg <= new_entry;
            s2_sum_reg   <= window_sum_next;
            s2_flags_reg <= s1_flags_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            window_sum_reg <= '0;
            for (int k = 0; k < WIN_DIM; k++) begin
                col_sums_reg[k] <= '0;
            end
        end else if (en && s1_valid_reg) begin
            window_sum_reg <= window_sum_next;
            for (int k = 0; k < WIN_DIM - 1; k++) begin
                col_sums_reg[k] <= col_sums_reg[k + 1];
            end
            col_sums_reg[WIN_DIM-1] <= csum;
        end
    end

    bmf_mean_div #(
        .WSUM_W (WSUM_W),
        .TAPS   (TAPS)
    ) u_div (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .in_valid  (s2_valid_reg),
        .in_sum    (s2_sum_reg),
        .in_flags  (s2_flags_reg),
        .out_valid (div_valid),
        .out_mean  (div_mean),
        .out_flags (div_flags)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (en) begin
            m_valid_reg <= div_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            m_mean_reg      <= div_mean;
            m_row_end_reg   <= div_flags.row_end;
            m_frame_end_reg <= div_flags.frame_end;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_mean_reg;
    assign m_tlast  = m_row_end_reg;
    assign m_tuser  = m_frame_end_reg;

endmodule

[sim/bmf_checker.sv]
// Checker for the box mean filter: tracks configuration writes, predicts window means, compares results.
`timescale 1ns / 1ps
module bmf_checker import bmf_pkg::*; (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   s_tvalid,
    input  logic                   s_tready,
    input  logic [7:0]             s_tdata,
    input  logic                   m_tvalid,
    input  logic                   m_tready,
    input  logic [15:0]            m_tdata,
    input  logic                   m_tlast,
    input  logic [0:0]             m_tuser,
    input  logic                   cfg_valid,
    input  logic                   cfg_ready,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data,
    output int                     fail_count,
    output int                     pending_means
);

    localparam int REACH      = 4;
    localparam int SPAN       = 2 * REACH + 1;
    localparam int HIST       = 2 * REACH;
    localparam int TAPS       = SPAN * SPAN;
    localparam int STORE_COLS = 1024;

    typedef struct packed {
        logic [MEAN_W-1:0] mean;
        logic              row_end;
        logic              frame_end;
    } window_mean_t;

    window_mean_t             mean_q[$];
    logic [PIXEL_W-1:0]       line_hist[STORE_COLS][HIST];
    int                       col_sum[SPAN];
    int                       box_sum;
    logic [COL_W-1:0]         col_pos;
    logic [ROW_W-1:0]         row_pos;
    logic [EXT_WIDTH_W-1:0]   width_reg;
    logic [EXT_HEIGHT_W-1:0]  height_reg;
    int                       misses = 0;

    task automatic clear_filter();
        for (int c = 0; c < STORE_COLS; c++) begin
            for (int k = 0; k < HIST; k++) begin
                line_hist[c][k] = '0;
            end
        end
        for (int k = 0; k < SPAN; k++) begin
            col_sum[k] = 0;
        end
        box_sum    = 0;
        col_pos    = '0;
        row_pos    = '0;
        width_reg  = EXT_WIDTH_RESET;
        height_reg = EXT_HEIGHT_RESET;
    endtask

    task automatic filter_pixel(input logic [PIXEL_W-1:0] px);
        int           w;
        int           h;
        int           slot;
        int           csum;
        int           mean;
        bit           last_col;
        bit           last_row;
        window_mean_t r;
        w = (int'(width_reg) > STORE_COLS) ? STORE_COLS : int'(width_reg);
        if (w == 0) w = 1;
        h = (height_reg == 0) ? 1 : int'(height_reg);
        slot = int'(col_pos) % STORE_COLS;

        // vertical sum, then push the pixel into its column history
        csum = int'(px);
        for (int k = 0; k < HIST; k++) begin
            csum += int'(line_hist[slot][k]);
        end
        for (int k = 0; k < HIST - 1; k++) begin
            line_hist[slot][k] = line_hist[slot][k+1];
        end
        line_hist[slot][HIST-1] = px;

        // horizontal running sum
        box_sum = box_sum + csum - col_sum[0];
        for (int k = 0; k < SPAN - 1; k++) begin
            col_sum[k] = col_sum[k+1];
        end
        col_sum[SPAN-1] = csum;

        last_col = (int'(col_pos) + 1 >= w);
        last_row = (int'(row_pos) + 1 >= h);

        if (row_pos >= HIST && col_pos >= HIST) begin
            mean = (box_sum * 256 + TAPS / 2) / TAPS;
            if (mean > int'(MEAN_MAX)) mean = int'(MEAN_MAX);
            r.mean      = mean[MEAN_W-1:0];
            r.row_end   = last_col;
            r.frame_end = last_col && last_row;
            mean_q.push_back(r);
        end

        if (last_col) begin
            col_pos = '0;
            row_pos = last_row ? '0 : row_pos + 1'b1;
        end else begin
            col_pos = col_pos + 1'b1;
        end
    endtask

    always @(posedge aclk) begin : watch
        window_mean_t head;
        if (!aresetn) begin
            clear_filter();
            mean_q.delete();
        end else begin
            if (cfg_valid && cfg_ready) begin
                if (cfg_index == CFG_EXT_WIDTH) begin
                    width_reg = cfg_data[EXT_WIDTH_W-1:0];
                end else if (cfg_index == CFG_EXT_HEIGHT) begin
                    height_reg = cfg_data[EXT_HEIGHT_W-1:0];
                end
            end
            if (m_tvalid && m_tready) begin
                if (mean_q.size() == 0) begin
                    $error("unexpected result: mean_value %0d row_end %0b frame_end %0b",
                           m_tdata, m_tlast, m_tuser[0]);
                    misses++;
                end else begin
                    head = mean_q.pop_front();
                    if (m_tdata !== head.mean) begin
                        $error("mean_value expected %0d actual %0d", head.mean, m_tdata);
                        misses++;
                    end
                    if (m_tlast !== head.row_end) begin
                        $error("row_end expected %0b actual %0b", head.row_end, m_tlast);
                        misses++;
                    end
                    if (m_tuser[0] !== head.frame_end) begin
                        $error("frame_end expected %0b actual %0b", head.frame_end, m_tuser[0]);
                        misses++;
                    end
                end
            end
            if (s_tvalid && s_tready) filter_pixel(s_tdata);
        end
        fail_count    <= misses;
        pending_means <= mean_q.size();
    end

endmodule

[sim/tb_box_mean_filter_9x9.sv]
// Testbench top for the 9x9 box mean filter: reset, stimulus, back pressure and verdict.
`timescale 1ns / 1ps
module tb_box_mean_filter_9x9;
    import bmf_pkg::*;

    localparam logic [CFG_INDEX_W-1:0] CFG_SPARE_A = ~CFG_EXT_WIDTH;
    localparam logic [CFG_INDEX_W-1:0] CFG_SPARE_B = ~CFG_EXT_HEIGHT;
    localparam int DRAIN_CYCLES = 16;

    logic                   aclk;
    logic                   aresetn;
    logic                   s_tvalid;
    logic                   s_tready;
    logic [7:0]             s_tdata;   // [7:0] pixel
    logic                   m_tvalid;
    logic                   m_tready;
    logic [15:0]            m_tdata;   // [15:0] mean_value
    logic                   m_tlast;   // row_end
    logic [0:0]             m_tuser;   // [0] frame_end
    logic                   cfg_valid;
    logic                   cfg_ready;
    logic [CFG_INDEX_W-1:0] cfg_index;
    logic [CFG_DATA_W-1:0]  cfg_data;

    int fail_count;
    int pending_means;
    bit calm     = 0;
    bit hold_req = 0;

    box_mean_filter_9x9 uut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast),
        .m_tuser   (m_tuser),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    bmf_checker mean_check (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_tvalid      (s_tvalid),
        .s_tready      (s_tready),
        .s_tdata       (s_tdata),
        .m_tvalid      (m_tvalid),
        .m_tready      (m_tready),
        .m_tdata       (m_tdata),
        .m_tlast       (m_tlast),
        .m_tuser       (m_tuser),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .fail_count    (fail_count),
        .pending_means (pending_means)
    );

    initial begin
        aclk = 1'b0;
        forever #1 aclk = ~aclk;
    end

    initial begin
        #1_000_000;
        $display("CHECK FAILED");
        $finish;
    end

    // result side: random stalls, plus one long hold-off on request
    initial begin
        m_tready = 1'b0;
        @(posedge aclk);
        forever begin
            if (hold_req) begin
                m_tready <= 1'b0;
                repeat (400) @(posedge aclk);
                hold_req = 0;
            end else begin
                m_tready <= calm || ($urandom_range(99) >= 6);
                @(posedge aclk);
            end
        end
    end

    function automatic logic [7:0] next_pixel();
        case ($urandom_range(7))
            0: return '0;
            1: return PIXEL_W'(PIXEL_MAX);
            default: return PIXEL_W'($urandom_range(PIXEL_MAX));
        endcase
    endfunction

    task automatic send_pixel(input logic [7:0] px);
        while (!calm && $urandom_range(99) < 6) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= px;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
    endtask

    task automatic send_run(input int n);
        for (int i = 0; i < n; i++) begin
            send_pixel(next_pixel());
        end
    endtask

    // stop sending, wait for every expected mean, then let the pipeline drain
    task automatic settle();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (pending_means != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        cfg_valid <= 1'b0;
        @(posedge aclk);
    endtask

    initial begin
        int                   sent;
        int                   count;
        int                   w_eff;
        int                   h_eff;
        logic [10:0]          w_val;
        logic [CFG_DATA_W-1:0] h_val;

        aresetn   = 1'b0;
        s_tvalid  = 1'b0;
        s_tdata   = '0;
        cfg_valid = 1'b0;
        cfg_index = '0;
        cfg_data  = '0;
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // reset geometry, then shrink the width while the column counter is past it
        send_run(20);
        settle();
        write_reg(CFG_EXT_WIDTH, 16'hF80C);
        write_reg(CFG_EXT_HEIGHT, 16'hFFFF);
        send_run(1 + 12 * 9);

        // widest line (saturated) on a row with full history, no idling,
        // with one long result-side hold-off
        settle();
        write_reg(CFG_EXT_WIDTH, 16'h07FF);
        calm     = 1;
        hold_req = 1;
        send_run(1024);
        calm = 0;
        settle();
        write_reg(CFG_EXT_WIDTH, 16'd12);
        write_reg(CFG_EXT_HEIGHT, 16'd12);
        send_run(12);

        // smallest window frame, all white
        settle();
        write_reg(CFG_EXT_WIDTH, 16'd9);
        write_reg(CFG_EXT_HEIGHT, 16'd9);
        for (int i = 0; i < 81; i++) send_pixel(PIXEL_W'(PIXEL_MAX));

        // zero width, zero height, too small images, unused register indexes
        settle();
        write_reg(CFG_EXT_WIDTH, 16'd0);
        write_reg(CFG_SPARE_A, 16'hFFFF);
        send_run(9);
        settle();
        write_reg(CFG_EXT_WIDTH, 16'd9);
        write_reg(CFG_EXT_HEIGHT, 16'd0);
        write_reg(CFG_SPARE_B, 16'h0000);
        send_run(9);
        settle();
        write_reg(CFG_EXT_WIDTH, 16'd8);
        write_reg(CFG_EXT_HEIGHT, 16'd9);
        send_run(72);
        settle();
        write_reg(CFG_EXT_WIDTH, 16'd9);
        write_reg(CFG_EXT_HEIGHT, 16'd8);
        send_run(72);

        sent = 0;
        while (sent < 120) begin
            settle();
            case ($urandom_range(9))
                0: w_val = 11'($urandom_range(0, 8));
                1: w_val = 11'($urandom_range(1025, 2047));
                default: w_val = 11'($urandom_range(9, 24));
            endcase
            case ($urandom_range(9))
                0: h_val = 16'($urandom_range(0, 8));
                1: h_val = 16'($urandom_range(1024, 65535));
                default: h_val = 16'($urandom_range(9, 16));
            endcase
            write_reg(CFG_EXT_WIDTH, {5'($urandom_range(31)), w_val});
            write_reg(CFG_EXT_HEIGHT, h_val);
            if ($urandom_range(3) == 0) write_reg(CFG_SPARE_A, 16'($urandom));

            w_eff = (w_val > 1024) ? 1024 : ((w_val == 0) ? 1 : int'(w_val));
            h_eff = (h_val == 0) ? 1 : int'(h_val);
            count = w_eff * h_eff * $urandom_range(1, 2);
            // sometimes stop mid-frame so the next write lands on running counters
            if ($urandom_range(3) == 0) count += $urandom_range(1, w_eff * h_eff - 1);
            if (count > 60) count = $urandom_range(20, 60);
            send_run(count);
            sent += count;
        end

        settle();
        if (fail_count == 0 && pending_means == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule
